// ----- hdl/iqp_pkg.sv -----
// Shared types and constants for the IQ to polar converter.
`default_nettype none
package iqp_pkg;

  // Fraction bits carried below the input LSB inside the rotation datapath
  localparam int GUARD_BITS = 16;

  // 1/K of the CORDIC gain in Q0.32
  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

  // Angle accumulator value for a half turn (2^31 = pi)
  localparam logic [31:0] HALF_TURN_Z = 32'h8000_0000;

  // Output phase codes for a vector lying on the I axis
  localparam logic [15:0] QUARTER_POS = 16'h4000;
  localparam logic [15:0] QUARTER_NEG = 16'hC000;

  // Rounding constant for the 32-bit accumulator to 16-bit phase
  localparam logic [31:0] PHASE_ROUND = 32'h0000_8000;

  // atan(2^-k) in accumulator units, 2^31 = pi
  localparam logic [31:0] ATAN_TABLE [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Input request: one complex sample
  typedef struct packed {
    logic signed [15:0] in_phase;
    logic signed [15:0] quadrature;
  } iqp_in_t;

  // Output request: polar form of the sample
  typedef struct packed {
    logic        [15:0] magnitude;
    logic signed [15:0] phase;
  } iqp_out_t;

  // Control travelling alongside the datapath
  typedef struct packed {
    logic valid;
    logic qzero;
    logic ineg;
  } iqp_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/iqp_pre.sv -----
// Input stage: sign extension, half-turn pre-rotation and guard-bit scaling.
`default_nettype none
module iqp_pre
  import iqp_pkg::*;
#(
  parameter int SW = 16,
  parameter int DW = 36
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire logic                 in_valid,
  input  wire iqp_in_t              in_data,
  output iqp_ctl_t                  ctl,
  output logic signed [DW-1:0]      x,
  output logic signed [DW-1:0]      y,
  output logic        [31:0]        z,
  output logic        [SW-1:0]      absi
);

  logic        [31:0]   raw_i;
  logic        [31:0]   raw_q;
  logic signed [SW:0]   i_s;
  logic signed [SW:0]   q_s;
  logic signed [DW-1:0] i_w;
  logic signed [DW-1:0] q_w;
  logic signed [SW:0]   i_neg;
  iqp_ctl_t             ctl_next;
  logic signed [DW-1:0] x_next;
  logic signed [DW-1:0] y_next;
  logic        [31:0]   z_next;
  logic        [SW-1:0] absi_next;

  // Keep the low SW bits of each word and sign-extend from bit SW-1
  always_comb begin
    raw_i = {16'b0, in_data.in_phase};
    raw_q = {16'b0, in_data.quadrature};
    i_s   = signed'({raw_i[SW-1], raw_i[SW-1:0]});
    q_s   = signed'({raw_q[SW-1], raw_q[SW-1:0]});
    i_w   = DW'(i_s);
    q_w   = DW'(q_s);
    i_neg = -i_s;
  end

  // Turn the vector by pi when Q is negative, then scale by the guard bits
  always_comb begin
    ctl_next.valid = in_valid;
    ctl_next.qzero = (q_s == '0);
    ctl_next.ineg  = i_s[SW];
    absi_next      = i_s[SW] ? i_neg[SW-1:0] : i_s[SW-1:0];
    if (q_s[SW]) begin
      x_next = (-q_w) <<< GUARD_BITS;
      y_next = (-i_w) <<< GUARD_BITS;
      z_next = HALF_TURN_Z;
    end else begin
      x_next = q_w <<< GUARD_BITS;
      y_next = i_w <<< GUARD_BITS;
      z_next = '0;
    end
  end

  // Advance the request; clear the valid bit under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (advance) begin
      ctl.valid <= ctl_next.valid;
    end
    if (advance) begin
      ctl.qzero <= ctl_next.qzero;
      ctl.ineg  <= ctl_next.ineg;
      x         <= x_next;
      y         <= y_next;
      z         <= z_next;
      absi      <= absi_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/iqp_stage.sv -----
// One registered vectoring CORDIC micro-rotation.
`default_nettype none
module iqp_stage
  import iqp_pkg::*;
#(
  parameter int SW = 16,
  parameter int DW = 36,
  parameter int K  = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire iqp_ctl_t             ctl_in,
  input  wire logic signed [DW-1:0] x_in,
  input  wire logic signed [DW-1:0] y_in,
  input  wire logic        [31:0]   z_in,
  input  wire logic        [SW-1:0] absi_in,
  output iqp_ctl_t                  ctl,
  output logic signed [DW-1:0]      x,
  output logic signed [DW-1:0]      y,
  output logic        [31:0]        z,
  output logic        [SW-1:0]      absi
);

  localparam logic [31:0] ATAN_K = ATAN_TABLE[K];

  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;
  logic signed [DW-1:0] x_next;
  logic signed [DW-1:0] y_next;
  logic        [31:0]   z_next;

  // Rotate towards the Q axis; y of zero rotates as for positive y
  always_comb begin
    xs = x_in >>> K;
    ys = y_in >>> K;
    if (!y_in[DW-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ATAN_K;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ATAN_K;
    end
  end

  // Advance the request; clear the valid bit under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (advance) begin
      ctl.valid <= ctl_in.valid;
    end
    if (advance) begin
      ctl.qzero <= ctl_in.qzero;
      ctl.ineg  <= ctl_in.ineg;
      x         <= x_next;
      y         <= y_next;
      z         <= z_next;
      absi      <= absi_in;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/iqp_gain.sv -----
// Gain removal, rounding, saturation and phase rounding over two stages.
`default_nettype none
module iqp_gain
  import iqp_pkg::*;
#(
  parameter int SW = 16,
  parameter int DW = 36
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire iqp_ctl_t             ctl_in,
  input  wire logic signed [DW-1:0] x_in,
  input  wire logic        [31:0]   z_in,
  input  wire logic        [SW-1:0] absi_in,
  output logic                      res_valid,
  output iqp_out_t                  res
);

  localparam int PW   = (DW > 32) ? DW : 33;
  localparam int HW   = PW - 32;
  localparam int SUMW = HW + 33;
  localparam logic [15:0] MAG_LIM = (SW >= 16) ? 16'hFFFF : 16'((1 << SW) - 1);

  logic [PW-1:0]    ux;
  iqp_ctl_t         ctl1;
  logic [63:0]      lo_prod;
  logic [HW+31:0]   hi_prod;
  logic [31:0]      z1;
  logic [SW-1:0]    absi1;
  logic [63:0]      lo_round;
  logic [SUMW-1:0]  sum;
  logic [SUMW-1:0]  mag_full;
  logic [31:0]      z_round;
  iqp_out_t         res_next;

  // Clamp negative x to zero and split it around bit 32
  always_comb begin
    ux = x_in[DW-1] ? '0 : PW'($unsigned(x_in));
  end

  // Stage one: multiply both halves by 1/K; clear the valid bit under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else if (advance) begin
      ctl1.valid <= ctl_in.valid;
    end
    if (advance) begin
      ctl1.qzero <= ctl_in.qzero;
      ctl1.ineg  <= ctl_in.ineg;
      lo_prod    <= 64'(ux[31:0]) * 64'(INV_GAIN_Q32);
      hi_prod    <= (HW + 32)'(ux[PW-1:32]) * (HW + 32)'(INV_GAIN_Q32);
      z1         <= z_in;
      absi1      <= absi_in;
    end
  end

  // Stage two: combine, drop guard bits with rounding, saturate, round the phase; a zero Q takes |I| instead
  always_comb begin
    lo_round = (lo_prod + 64'h0000_0000_8000_0000) >> 32;
    sum      = SUMW'(hi_prod) + SUMW'(lo_round[32:0]);
    mag_full = (sum + SUMW'(32'h0000_8000)) >> GUARD_BITS;
    z_round  = z1 + PHASE_ROUND;
    if (ctl1.qzero) begin
      res_next.magnitude = (33'(absi1) > 33'(MAG_LIM)) ? MAG_LIM : 16'(absi1);
      res_next.phase     = ctl1.ineg ? QUARTER_NEG : QUARTER_POS;
    end else begin
      res_next.magnitude = (mag_full > SUMW'(MAG_LIM)) ? MAG_LIM : mag_full[15:0];
      res_next.phase     = z_round[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= ctl1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/iq_to_polar_converter.sv -----
// IQ to polar converter: pipelined vectoring CORDIC with output skid stage.
// Path from request accepted to out_valid: input stage, micro-rotation stages, gain stages, output register.
// Throughput: one request per cycle while the skid register is free; each micro-rotation has its own register stage.
// Stall: the pipeline halts only when both output register and skid register are full.
// Reset: synchronous rst clears every valid bit; payload registers are not reset.
`default_nettype none
module iq_to_polar_converter
  import iqp_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire iqp_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output iqp_out_t      out_data
);

  localparam int NST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int DW  = SAMPLE_WIDTH + GUARD_BITS + 4;

  logic                    advance;
  iqp_ctl_t                ctl  [NST+1];
  logic signed [DW-1:0]    xv   [NST+1];
  logic signed [DW-1:0]    yv   [NST+1];
  logic        [31:0]      zv   [NST+1];
  logic [SAMPLE_WIDTH-1:0] absi [NST+1];
  logic                    res_valid;
  iqp_out_t                res;
  logic                    skid_full;
  iqp_out_t                skid_data;

  // Move the pipeline whenever the skid register is free
  always_comb begin
    advance  = !skid_full;
    in_stall = skid_full;
  end

  iqp_pre #(
    .SW (SAMPLE_WIDTH),
    .DW (DW)
  ) u_pre (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (in_valid),
    .in_data  (in_data),
    .ctl      (ctl[0]),
    .x        (xv[0]),
    .y        (yv[0]),
    .z        (zv[0]),
    .absi     (absi[0])
  );

  // One register stage per micro-rotation
  for (genvar k = 0; k < NST; k++) begin : g_stage
    iqp_stage #(
      .SW (SAMPLE_WIDTH),
      .DW (DW),
      .K  (k)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .ctl_in  (ctl[k]),
      .x_in    (xv[k]),
      .y_in    (yv[k]),
      .z_in    (zv[k]),
      .absi_in (absi[k]),
      .ctl     (ctl[k+1]),
      .x       (xv[k+1]),
      .y       (yv[k+1]),
      .z       (zv[k+1]),
      .absi    (absi[k+1])
    );
  end

  iqp_gain #(
    .SW (SAMPLE_WIDTH),
    .DW (DW)
  ) u_gain (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .ctl_in    (ctl[NST]),
    .x_in      (xv[NST]),
    .z_in      (zv[NST]),
    .absi_in   (absi[NST]),
    .res_valid (res_valid),
    .res       (res)
  );

  // Load the output register from the skid first; park a result when stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_full ? skid_data : res;
    end else if (!skid_full) begin
      skid_data <= res;
    end
  end

endmodule
`default_nettype wire

// ----- test/tb_iq_to_polar_converter.sv -----
// Testbench for the IQ to polar converter: directed table, then random samples under idling and output stalls.
`default_nettype none
module tb_iq_to_polar_converter;
  import iqp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES     = 16;
  localparam int LATENCY    = STAGES + 3;
  localparam int PER_PHASE  = 383;
  localparam int MAX_REPORT = 100;

  // atan(2^-k) with 2^31 standing for a half turn
  localparam logic [31:0] ARCTAN_STEP [STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };
  localparam longint unsigned GAIN_RECIP = 64'd2608131496;

  // One directed row: sample, and the result where it is obvious by inspection
  typedef struct packed {
    logic signed [15:0] i;
    logic signed [15:0] q;
    logic               typed;
    iqp_out_t           want;
  } probe_t;

  localparam int NPROBES = 21;
  localparam probe_t PROBES [NPROBES] = '{
    // on the I axis: length is |I|, phase a quarter turn by sign of I
    '{16'sd0,       16'sd0,       1'b1, '{16'd0,     16'sh4000}},
    '{16'sd32767,   16'sd0,       1'b1, '{16'd32767, 16'sh4000}},
    '{16'sh8000,    16'sd0,       1'b1, '{16'd32768, 16'shC000}},
    '{-16'sd1,      16'sd0,       1'b1, '{16'd1,     16'shC000}},
    '{16'sd1,       16'sd0,       1'b1, '{16'd1,     16'sh4000}},
    // on the Q axis, both signs; negative Q wraps to minus a half turn
    '{16'sd0,       16'sd32767,   1'b0, '{16'd0, 16'sd0}},
    '{16'sd0,       16'sh8000,    1'b0, '{16'd0, 16'sd0}},
    '{16'sd0,       -16'sd1,      1'b0, '{16'd0, 16'sd0}},
    '{16'sd0,       16'sd1,       1'b0, '{16'd0, 16'sd0}},
    // corners: largest lengths
    '{16'sd32767,   16'sd32767,   1'b0, '{16'd0, 16'sd0}},
    '{16'sh8000,    16'sh8000,    1'b0, '{16'd0, 16'sd0}},
    '{16'sd32767,   16'sh8000,    1'b0, '{16'd0, 16'sd0}},
    '{16'sh8000,    16'sd32767,   1'b0, '{16'd0, 16'sd0}},
    // unit diagonals in all four quadrants
    '{16'sd1,       16'sd1,       1'b0, '{16'd0, 16'sd0}},
    '{-16'sd1,      -16'sd1,      1'b0, '{16'd0, 16'sd0}},
    '{16'sd1,       -16'sd1,      1'b0, '{16'd0, 16'sd0}},
    '{-16'sd1,      16'sd1,       1'b0, '{16'd0, 16'sd0}},
    // alternating bit patterns
    '{16'sh5555,    16'shAAAA,    1'b0, '{16'd0, 16'sd0}},
    '{16'shAAAA,    16'sh5555,    1'b0, '{16'd0, 16'sd0}},
    // slightly negative Q, close to a quarter turn either side
    '{16'sd100,     -16'sd3,      1'b0, '{16'd0, 16'sd0}},
    '{-16'sd100,    -16'sd3,      1'b0, '{16'd0, 16'sd0}}
  };

  typedef struct {
    iqp_in_t  src;
    iqp_out_t want;
  } due_t;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  iqp_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  iqp_out_t out_data;

  due_t polar_due [$];
  due_t head;
  int   mismatch_count = 0;
  int   send_idle_pct  = 0;
  int   stall_pct      = 0;

  iq_to_polar_converter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Compute the expected polar form of one sample
  function automatic iqp_out_t polar_of(iqp_in_t s);
    longint          x, y, nx, xs, ys;
    longint unsigned ux, prod, mag;
    logic [31:0]     z, zr;
    iqp_out_t        r;
    x = longint'(s.quadrature);
    y = longint'(s.in_phase);
    z = '0;
    // Q zero: length is |I|, phase a quarter turn by the sign of I
    if (s.quadrature == 0) begin
      mag = (y < 0) ? -y : y;
      r.magnitude = (mag > 64'd65535) ? 16'hFFFF : mag[15:0];
      r.phase = (y < 0) ? 16'shC000 : 16'sh4000;
      return r;
    end
    // turn the left half plane by a half turn first
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    x = x * 65536;
    y = y * 65536;
    // drive y towards zero; y equal to zero rotates as positive
    for (int k = 0; k < STAGES; k++) begin
      ys = y >>> k;
      xs = x >>> k;
      if (y >= 0) begin
        nx = x + ys;
        y  = y - xs;
        z  = z + ARCTAN_STEP[k];
      end else begin
        nx = x - ys;
        y  = y + xs;
        z  = z - ARCTAN_STEP[k];
      end
      x = nx;
    end
    // remove the gain, then drop the guard bits with rounding
    ux   = (x > 0) ? x : 0;
    prod = (ux >> 32) * GAIN_RECIP
         + (((ux & 64'hFFFF_FFFF) * GAIN_RECIP + 64'h8000_0000) >> 32);
    mag  = (prod + 64'd32768) >> 16;
    r.magnitude = (mag > 64'd65535) ? 16'hFFFF : mag[15:0];
    zr = z + 32'h0000_8000;
    r.phase = zr[31:16];
    return r;
  endfunction

  // Draw a random sample, biased towards axes, extremes and small values
  function automatic iqp_in_t random_sample();
    iqp_in_t      s;
    logic [31:0]  r;
    logic [15:0]  ext [5];
    ext = '{16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h0000};
    r = $urandom;
    s.in_phase   = 16'($urandom);
    s.quadrature = 16'($urandom);
    case ($urandom_range(9))
      0: s.quadrature = '0;
      1: s.in_phase = '0;
      2: begin
        s.in_phase   = {{10{r[5]}}, r[5:0]};
        s.quadrature = {{10{r[13]}}, r[13:8]};
      end
      3: begin
        s.in_phase   = ext[$urandom_range(4)];
        s.quadrature = ext[$urandom_range(4)];
      end
      4: s.quadrature = {{12{r[3]}}, r[3:0]};
      5: s.in_phase = {{12{r[3]}}, r[3:0]};
      default: ;
    endcase
    return s;
  endfunction

  // Offer one request, wait for it to be taken, then log what it must produce
  task automatic offer(input iqp_in_t s, input logic typed, input iqp_out_t want);
    due_t d;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    d.src  = s;
    d.want = typed ? want : polar_of(s);
    polar_due.push_back(d);
  endtask

  // Check each result taken from the block, and drive the stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (polar_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORT)
          $display("%0t: result with none pending: magnitude %0d phase %0d",
                   $time, out_data.magnitude, out_data.phase);
      end else begin
        head = polar_due.pop_front();
        if (out_data.magnitude !== head.want.magnitude ||
            out_data.phase !== head.want.phase) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORT)
            $display("%0t: I %0d Q %0d: expected magnitude %0d phase %0d, got %0d %0d",
                     $time, head.src.in_phase, head.src.quadrature,
                     head.want.magnitude, head.want.phase,
                     out_data.magnitude, out_data.phase);
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Stimulus: directed table, then random samples over the idling phases
  initial begin
    iqp_in_t s;
    int      send_by_phase  [4];
    int      stall_by_phase [4];
    send_by_phase  = '{0, 50, 0, 30};
    stall_by_phase = '{0, 0, 50, 30};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < NPROBES; n++) begin
      s.in_phase   = PROBES[n].i;
      s.quadrature = PROBES[n].q;
      offer(s, PROBES[n].typed, PROBES[n].want);
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_by_phase[p];
      stall_pct     = stall_by_phase[p];
      for (int n = 0; n < PER_PHASE; n++)
        offer(random_sample(), 1'b0, '0);
    end

    // drain: no more requests, no more stalls
    in_valid <= 1'b0;
    stall_pct = 0;
    while (polar_due.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
